// ===== sv/fpa_pkg.sv =====
// Package: shared types, operation codes and status codes for the fixed-point ALU.
package fpa_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_SAT = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0] kind;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_word;
    logic compare_true;
    logic [1:0] status;
  } out_item_t;

endpackage

// ===== sv/fpa_simple.sv =====
// Combinational ops (add/sub/compare/min/max/inc/dec/convert), delayed through DEPTH registers.
module fpa_simple import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  in_item_t  in_item,
  output out_item_t out_item
);
  out_item_t res;
  out_item_t dly_r [DEPTH];
  logic signed [WORD_W-1:0] a, b;
  logic signed [WORD_W-1:0] q;
  logic [WORD_W-1:0] bias;

  assign a = in_item.operand_a;
  assign b = in_item.operand_b;

  always_comb begin
    res = '0;
    q = '0;
    bias = '0;
    case (op_t'(in_item.kind))
      OP_ADD: res.result_word = a + b;
      OP_SUB: res.result_word = a - b;
      OP_GT: res.compare_true = a > b;
      OP_LT: res.compare_true = a < b;
      OP_GE: res.compare_true = a >= b;
      OP_LE: res.compare_true = a <= b;
      OP_EQ: res.compare_true = a == b;
      OP_NE: res.compare_true = a != b;
      OP_MIN: res.result_word = (a < b) ? a : b;
      OP_MAX: res.result_word = (a > b) ? a : b;
      OP_INC: res.result_word = a + 32'sd1;
      OP_DEC: res.result_word = a - 32'sd1;
      OP_FROM_INT: res.result_word = a <<< FRAC_BITS;
      OP_TO_INT: begin
        // bias negatives so the arithmetic shift truncates toward zero
        bias = a[WORD_W-1] ? WORD_W'((64'd1 << FRAC_BITS) - 64'd1) : '0;
        q = (a + $signed(bias)) >>> FRAC_BITS;
        res.result_word = q;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= res;
    for (int i = 1; i < DEPTH; i++) dly_r[i] <= dly_r[i-1];
  end

  assign out_item = dly_r[DEPTH-1];
endmodule

// ===== sv/fpa_mul.sv =====
// Pipelined signed multiply: partial products of 16-bit halves, sum, scale and saturate.
module fpa_mul import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  output logic signed [WORD_W-1:0] result,
  output logic                     sat
);
  // magnitudes, split into halves
  logic [WORD_W-1:0] ma_r, mb_r;
  logic neg_r, neg2_r, neg3_r;
  logic [WORD_W-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [63:0] prod_r;
  logic [63:0] q;
  logic signed [WORD_W-1:0] res_r;
  logic sat_r;
  logic signed [WORD_W-1:0] dly_r [DEPTH];
  logic dsat_r [DEPTH];

  always_ff @(posedge clk) begin
    ma_r <= a[WORD_W-1] ? WORD_W'(-a) : a;
    mb_r <= b[WORD_W-1] ? WORD_W'(-b) : b;
    neg_r <= a[WORD_W-1] ^ b[WORD_W-1];
    pll_r <= ma_r[15:0] * mb_r[15:0];
    plh_r <= ma_r[15:0] * mb_r[31:16];
    phl_r <= ma_r[31:16] * mb_r[15:0];
    phh_r <= ma_r[31:16] * mb_r[31:16];
    neg2_r <= neg_r;
    prod_r <= {phh_r, pll_r} + {16'd0, plh_r, 16'd0} + {16'd0, phl_r, 16'd0};
    neg3_r <= neg2_r;
  end

  // magnitude shift truncates toward zero
  assign q = prod_r >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!neg3_r) begin
      sat_r <= q > 64'h7FFF_FFFF;
      res_r <= (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : WORD_W'(q);
    end else begin
      sat_r <= q > 64'h8000_0000;
      res_r <= (q > 64'h8000_0000) ? 32'sh8000_0000 : WORD_W'(-q);
    end
    dly_r[0] <= res_r;
    dsat_r[0] <= sat_r;
    for (int i = 1; i < DEPTH; i++) begin
      dly_r[i] <= dly_r[i-1];
      dsat_r[i] <= dsat_r[i-1];
    end
  end

  assign result = dly_r[DEPTH-1];
  assign sat = dsat_r[DEPTH-1];
endmodule

// ===== sv/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sign fix and saturation.
module fpa_div import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  output logic signed [WORD_W-1:0] result,
  output logic [1:0]               status
);
  localparam int NW = WORD_W + FRAC_BITS;   // dividend width
  localparam int STG = NW;                  // one quotient bit per stage

  logic [NW-1:0] n_r [STG+1];
  logic [WORD_W:0] rem_r [STG+1];
  logic [WORD_W-1:0] d_r [STG+1];
  logic neg_r [STG+1];
  logic z_r [STG+1];
  logic [WORD_W-1:0] ma, mb;
  logic signed [WORD_W-1:0] res_r;
  logic [1:0] st_r;

  assign ma = a[WORD_W-1] ? WORD_W'(-a) : a;
  assign mb = b[WORD_W-1] ? WORD_W'(-b) : b;

  always_ff @(posedge clk) begin
    n_r[0] <= NW'({ma, {FRAC_BITS{1'b0}}});
    rem_r[0] <= '0;
    d_r[0] <= mb;
    neg_r[0] <= a[WORD_W-1] ^ b[WORD_W-1];
    z_r[0] <= (b == '0);
    for (int s = 0; s < STG; s++) begin : step
      logic [WORD_W+1:0] t;
      t = {rem_r[s], n_r[s][NW-1]};
      if (t >= {2'b00, d_r[s]}) begin
        rem_r[s+1] <= (WORD_W+1)'(t - {2'b00, d_r[s]});
        n_r[s+1] <= {n_r[s][NW-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= t[WORD_W:0];
        n_r[s+1] <= {n_r[s][NW-2:0], 1'b0};
      end
      d_r[s+1] <= d_r[s];
      neg_r[s+1] <= neg_r[s];
      z_r[s+1] <= z_r[s];
    end
    if (z_r[STG]) begin
      res_r <= '0;
      st_r <= ST_DIV_ZERO;
    end else if (!neg_r[STG]) begin
      res_r <= (n_r[STG] > NW'(33'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : WORD_W'(n_r[STG]);
      st_r <= (n_r[STG] > NW'(33'h7FFF_FFFF)) ? ST_SAT : ST_OK;
    end else begin
      res_r <= (n_r[STG] > NW'(33'h8000_0000)) ? 32'sh8000_0000 : WORD_W'(-n_r[STG]);
      st_r <= (n_r[STG] > NW'(33'h8000_0000)) ? ST_SAT : ST_OK;
    end
  end

  assign result = res_r;
  assign status = st_r;
endmodule

// ===== sv/fixed_point_alu.sv =====
// Top level: fixed-point ALU pipeline with valid tracking and result merge.
// Signed Q-format ALU, 32-bit words with FRAC_BITS fraction bits. A transaction is
// accepted whenever start is high; busy is always low, so one operation enters every
// clock. Every operation, simple or not, goes through the same pipeline depth, set by
// the divider, which resolves one quotient bit per pipeline stage. Results leave in
// order with out_valid high for exactly one cycle; the receiver cannot stall, and
// nothing is buffered.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  // divider: input reg + NW stages + output reg
  localparam int LAT = WORD_W + FRAC_BITS + 2;
  // multiplier register stages ahead of its delay line
  localparam int MUL_LAT = 4;

  logic [LAT-1:0] vld_r;
  logic [3:0] kind_r [LAT];
  out_item_t simple;
  logic signed [WORD_W-1:0] mul_res, div_res;
  logic mul_sat;
  logic [1:0] div_st;
  out_item_t res_nxt, res_r;
  logic out_valid_r;

  assign busy = 1'b0;

  fpa_simple #(.FRAC_BITS(FRAC_BITS), .DEPTH(LAT)) u_simple (
    .clk, .in_item, .out_item(simple));

  fpa_mul #(.FRAC_BITS(FRAC_BITS), .DEPTH(LAT - MUL_LAT)) u_mul (
    .clk, .a(in_item.operand_a), .b(in_item.operand_b), .result(mul_res), .sat(mul_sat));

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .a(in_item.operand_a), .b(in_item.operand_b), .result(div_res), .status(div_st));

  // valid bits travel alongside the operation code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
      out_valid_r <= vld_r[LAT-1];
    end
    kind_r[0] <= in_item.kind;
    for (int i = 1; i < LAT; i++) kind_r[i] <= kind_r[i-1];
  end

  // pick the unit that owns the operation
  always_comb begin
    res_nxt = simple;
    case (op_t'(kind_r[LAT-1]))
      OP_MUL: begin
        res_nxt = '0;
        res_nxt.result_word = mul_res;
        res_nxt.status = mul_sat ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        res_nxt = '0;
        res_nxt.result_word = div_res;
        res_nxt.status = div_st;
      end
      default: res_nxt = simple;
    endcase
  end

  always_ff @(posedge clk) res_r <= res_nxt;

  assign out_valid = out_valid_r;
  assign out_item = res_r;

  // every accepted transaction comes out with out_valid high
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LAT+1) out_valid) else $error("lost transaction");
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.compare_true |-> out_item.result_word == '0)
    else $error("compare with nonzero word");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> !out_item.compare_true)
    else $error("status on compare");
endmodule
